### rtl/sdwt_pkg.sv
// ----------------------------------------------------------------------------
// sdwt_pkg
// Shared types and codes of the sleep deadline wakeup table.
// ----------------------------------------------------------------------------
package sdwt_pkg;

  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_WOKEN    = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // payload of one sleeper slot
  typedef struct packed {
    logic [7:0]  thread;
    logic [63:0] deadline;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic load;   // sleep insert into the first free cell
    logic shift;  // one scan step: chain moves toward the head
    logic keep;   // head entry is not due and is appended at the end
  } ctl_t;

endpackage

### rtl/sdwt_cell.sv
// ----------------------------------------------------------------------------
// sdwt_cell
// One sleeper slot of the chain: valid flag, thread id and deadline.
// ----------------------------------------------------------------------------
module sdwt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sdwt_pkg::ctl_t ctl,
  input  sdwt_pkg::entry_t ins_data,
  input  logic           nb_valid,
  input  sdwt_pkg::entry_t nb_data,
  input  logic           prv_valid,
  output logic           valid,
  output sdwt_pkg::entry_t data
);
  import sdwt_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  entry_t data_r;
  entry_t data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.shift) begin
      valid_nxt = nb_valid;
      data_nxt  = nb_data;
      // last occupied cell takes the recirculated head entry
      if (ctl.keep && !nb_valid && valid_r) begin
        valid_nxt = 1'b1;
        data_nxt  = ins_data;
      end
    end else if (ctl.load && !valid_r && prv_valid) begin
      valid_nxt = 1'b1;
      data_nxt  = ins_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

### rtl/sleep_deadline_wakeup_table_unit.sv
// ----------------------------------------------------------------------------
// sleep_deadline_wakeup_table_unit
// Tick counter with a table of sleeping threads and their wake deadlines.
// ----------------------------------------------------------------------------
// A sleep request is taken when start is high and busy is low and its single
// result (accepted or table full) shows on the out_ ports in the next cycle;
// busy stays low, so sleep requests can be issued every cycle. A tick raises
// busy and walks the chain of sleeper cells one slot per cycle, one step for
// each occupied slot. Each due sleeper gives a woken beat, in insertion order,
// then a tick done beat closes the tick. Every result is valid for exactly
// one cycle under out_strobe and cannot be held off, so the receiver must
// take each beat as it comes.
module sleep_deadline_wakeup_table_unit #(
  parameter int SLEEPER_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [7:0]         in_thread_id,
  input  logic signed [31:0] in_sleep_ticks,
  output logic               out_strobe,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_woken_id,
  output logic [62:0]        out_tick_now,
  output logic               out_last
);
  import sdwt_pkg::*;

  localparam int CW = $clog2(SLEEPER_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_FULL = CW'(SLEEPER_SLOTS);
  localparam logic [CW-1:0] CNT_ONE    = CW'(1);

  logic [63:0]   tick_count_r, tick_count_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          busy_r, busy_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_woken_id_r, out_woken_id_nxt;
  logic [62:0]   out_tick_now_r, out_tick_now_nxt;
  logic          out_last_r, out_last_nxt;

  logic   cell_valid [SLEEPER_SLOTS];
  entry_t cell_data  [SLEEPER_SLOTS];

  logic        accept;
  logic        full;
  logic        step;
  logic        expired;
  logic [63:0] sleep_deadline;
  ctl_t        ctl;
  entry_t      ins_data;

  assign accept  = start && !busy_r;
  assign full    = (cnt_r == SLOTS_FULL);
  assign step    = busy_r && (rem_r != '0);
  assign expired = $signed(cell_data[0].deadline) <= $signed(tick_count_r);
  assign sleep_deadline = tick_count_r + {{32{in_sleep_ticks[31]}}, in_sleep_ticks};

  assign ctl.load  = accept && (in_operation == OP_SLEEP) && !full;
  assign ctl.shift = step;
  assign ctl.keep  = !expired;

  assign ins_data = step ? cell_data[0] :
                    entry_t'{thread: in_thread_id, deadline: sleep_deadline};

  for (genvar i = 0; i < SLEEPER_SLOTS; i++) begin : g_cell
    logic   nb_valid;
    entry_t nb_data;
    logic   prv_valid;
    if (i == SLEEPER_SLOTS - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_data  = ins_data;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_data  = cell_data[i+1];
    end
    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = cell_valid[i-1];
    end
    sdwt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_data  (ins_data),
      .nb_valid  (nb_valid),
      .nb_data   (nb_data),
      .prv_valid (prv_valid),
      .valid     (cell_valid[i]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    tick_count_nxt   = tick_count_r;
    cnt_nxt          = cnt_r;
    rem_nxt          = rem_r;
    busy_nxt         = busy_r;
    out_strobe_nxt   = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_woken_id_nxt = out_woken_id_r;
    out_tick_now_nxt = out_tick_now_r;
    out_last_nxt     = out_last_r;
    if (busy_r) begin
      out_tick_now_nxt = tick_count_r[62:0];
      if (step) begin
        rem_nxt = rem_r - CNT_ONE;
        if (expired) begin
          cnt_nxt          = cnt_r - CNT_ONE;
          out_strobe_nxt   = 1'b1;
          out_kind_nxt     = KIND_WOKEN;
          out_woken_id_nxt = cell_data[0].thread;
          out_last_nxt     = 1'b0;
        end
      end else begin
        busy_nxt         = 1'b0;
        out_strobe_nxt   = 1'b1;
        out_kind_nxt     = KIND_DONE;
        out_woken_id_nxt = 8'd0;
        out_last_nxt     = 1'b1;
      end
    end else if (accept) begin
      if (in_operation == OP_TICK) begin
        tick_count_nxt = tick_count_r + 64'd1;
        rem_nxt        = cnt_r;
        busy_nxt       = 1'b1;
      end else begin
        out_strobe_nxt   = 1'b1;
        out_kind_nxt     = full ? KIND_FULL : KIND_ACCEPTED;
        out_woken_id_nxt = in_thread_id;
        out_tick_now_nxt = tick_count_r[62:0];
        out_last_nxt     = 1'b1;
        if (!full) begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      cnt_r        <= '0;
      rem_r        <= '0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      tick_count_r <= tick_count_nxt;
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      busy_r       <= busy_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r     <= out_kind_nxt;
    out_woken_id_r <= out_woken_id_nxt;
    out_tick_now_r <= out_tick_now_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign busy         = busy_r;
  assign out_strobe   = out_strobe_r;
  assign out_kind     = out_kind_r;
  assign out_woken_id = out_woken_id_r;
  assign out_tick_now = out_tick_now_r;
  assign out_last     = out_last_r;

endmodule

### rtl/sdwt_checker.sv
// ----------------------------------------------------------------------------
// sdwt_checker
// Port-level checks of the sleep deadline wakeup table, bound to the top.
// ----------------------------------------------------------------------------
module sdwt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_operation,
  input logic [7:0]         in_thread_id,
  input logic               out_strobe,
  input logic [1:0]         out_kind,
  input logic [7:0]         out_woken_id,
  input logic               out_last
);
  import sdwt_pkg::*;

  // a sleep beat answers in the next cycle with its own thread id
  a_sleep_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_SLEEP) |=>
      out_strobe && out_last && out_woken_id == $past(in_thread_id) &&
      (out_kind == KIND_ACCEPTED || out_kind == KIND_FULL))
    else $error("sleep beat without matching reply");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_TICK) |=> busy && !out_strobe)
    else $error("tick did not enter scan");

  // busy drops exactly when the tick done beat goes out
  a_tick_close: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe && out_kind == KIND_DONE &&
      out_last && out_woken_id == 8'd0)
    else $error("tick closed without done beat");

  a_woken_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_WOKEN |-> busy && !out_last)
    else $error("woken beat outside a tick scan");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("reset did not clear control");

endmodule

bind sleep_deadline_wakeup_table_unit sdwt_checker u_sdwt_checker (.*);
